>>> rtl/inband_packet_deframer_core_macros.svh
// Assertion macros shared by the deframer RTL.
// Expects clk and arst_n in the scope where a macro is used.
`ifndef INBAND_PACKET_DEFRAMER_CORE_MACROS_SVH
`define INBAND_PACKET_DEFRAMER_CORE_MACROS_SVH

// same-cycle implication, disabled while in reset
`define IPD_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("deframer assertion failed");

// next-cycle implication, disabled while in reset
`define IPD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("deframer assertion failed");

`endif

>>> rtl/ipd_pkg.sv
// Package for the in-band packet deframer: packet geometry, header field
// positions, register indexes and the timekeeper control struct. No dependencies.
package ipd_pkg;

	localparam int PACKET_WORDS = 128;
	localparam int IDX_W        = $clog2(PACKET_WORDS);
	// payload word count comes from a 9-bit byte count, so at least 7 bits
	localparam int CNT_W        = (IDX_W > 7) ? IDX_W : 7;

	localparam logic [4:0]  CHAN_DATA      = 5'h00;
	localparam logic [4:0]  CHAN_CTRL      = 5'h1f;
	localparam logic [15:0] PING_REPLY_TAG = 16'h0102;

	localparam logic [IDX_W-1:0] IDX_HEADER = IDX_W'(0);
	localparam logic [IDX_W-1:0] IDX_STAMP  = IDX_W'(1);
	localparam logic [IDX_W-1:0] IDX_PING   = IDX_W'(2);
	localparam logic [IDX_W-1:0] IDX_LAST   = IDX_W'(PACKET_WORDS - 1);
	localparam logic [CNT_W-1:0] PAYLOAD_CAP = CNT_W'(PACKET_WORDS - 2);

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef enum logic [1:0] {
		CFG_PING_TIME   = 2'd0,
		CFG_PING_OFFSET = 2'd1
	} cfg_reg_t;

	// events for the timekeeper, already qualified by the stage advancing
	typedef struct packed {
		logic        stamp_word;  // word 1 of any packet
		logic        data_chan;   // current packet is on the data channel
		logic        ping_reply;  // ping reply recognized in word 2
		logic [31:0] stamp;       // low timestamp from word 1
	} tk_ctl_t;

	// configuration write request
	typedef struct packed {
		logic        wr;
		logic [1:0]  index;
		logic [63:0] data;
	} cfg_wr_t;

	function automatic cnt_t payload_count(input logic [31:0] hdr);
		cnt_t words;
		words = CNT_W'(hdr[8:2]);
		return (words > PAYLOAD_CAP) ? PAYLOAD_CAP : words;
	endfunction

endpackage

>>> rtl/inband_packet_deframer_core.sv
// In-band packet deframer, top level. Uses ipd_pkg and ipd_timekeeper.
// Assertions come from inband_packet_deframer_core_macros.svh.

// Takes one 32-bit stream word per cycle in fixed 128-word packets (word 0
// header, word 1 timestamp) and emits channel-0 payload words with a 64-bit
// host time once a ping reply on the control channel has aligned the clock.
// An accepted word passes the input register, then decode plus the sample-time
// add into the result register. Throughput is one word per cycle while the
// sample side takes results; a stall on the sample side backs up through the
// two registers. Configuration writes are always accepted and must only be
// made while the block is idle.
module inband_packet_deframer_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        stream_valid,
	output logic        stream_ready,
	input  logic [31:0] stream_word,
	output logic        sample_valid,
	input  logic        sample_ready,
	output logic [31:0] sample_word,
	output logic [63:0] sample_time,
	output logic [5:0]  rssi,
	output logic        underrun,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data
);
	import ipd_pkg::*;

	logic        s1_valid_q;
	logic [31:0] word_s1;

	idx_t        word_index_q;
	logic [4:0]  channel_q;
	cnt_t        payload_words_q;
	logic [5:0]  hdr_rssi_q;
	logic        hdr_underrun_q;

	logic        out_valid_q;
	logic [31:0] sample_word_q;
	logic [63:0] sample_time_q;
	logic [5:0]  rssi_q;
	logic        underrun_q;

	logic        advance;
	logic        take_s1;
	logic        emit;
	cnt_t        sample_k;
	logic        aligned;
	logic [63:0] time_base;
	tk_ctl_t     tk_ctl;
	cfg_wr_t     cfg_wr;

	assign advance      = !out_valid_q || sample_ready;
	assign take_s1      = s1_valid_q && advance;
	assign stream_ready = !s1_valid_q || advance;
	assign cfg_ready    = 1'b1;

	assign sample_k = CNT_W'(word_index_q - IDX_PING);
	assign emit     = (word_index_q != IDX_HEADER) && (word_index_q != IDX_STAMP)
		&& (channel_q == CHAN_DATA) && aligned && (sample_k < payload_words_q);

	always_comb begin
		tk_ctl.stamp_word = take_s1 && (word_index_q == IDX_STAMP);
		tk_ctl.data_chan  = (channel_q == CHAN_DATA);
		tk_ctl.ping_reply = take_s1 && (word_index_q == IDX_PING)
			&& (channel_q == CHAN_CTRL) && (word_s1[31:16] == PING_REPLY_TAG);
		tk_ctl.stamp      = word_s1;
		cfg_wr.wr         = cfg_valid && cfg_ready;
		cfg_wr.index      = cfg_index;
		cfg_wr.data       = cfg_data;
	end

	ipd_timekeeper u_timekeeper (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (tk_ctl),
		.cfg       (cfg_wr),
		.aligned   (aligned),
		.time_base (time_base)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (stream_ready) begin
			s1_valid_q <= stream_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (stream_ready && stream_valid) begin
			word_s1 <= stream_word;
		end
	end

	// packet position and header fields
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_index_q    <= '0;
			channel_q       <= '0;
			payload_words_q <= '0;
			hdr_rssi_q      <= '0;
			hdr_underrun_q  <= 1'b0;
		end else if (take_s1) begin
			word_index_q <= (word_index_q == IDX_LAST) ? IDX_HEADER : word_index_q + idx_t'(1);
			if (word_index_q == IDX_HEADER) begin
				channel_q       <= word_s1[20:16];
				payload_words_q <= payload_count(word_s1);
				hdr_rssi_q      <= word_s1[26:21];
				hdr_underrun_q  <= word_s1[30];
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= s1_valid_q && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1 && emit) begin
			sample_word_q <= word_s1;
			sample_time_q <= time_base + 64'(sample_k);
			rssi_q        <= hdr_rssi_q;
			underrun_q    <= hdr_underrun_q;
		end
	end

	assign sample_valid = out_valid_q;
	assign sample_word  = sample_word_q;
	assign sample_time  = sample_time_q;
	assign rssi         = rssi_q;
	assign underrun     = underrun_q;

`include "inband_packet_deframer_core_macros.svh"

	`IPD_ASSERT_NOW(a_sample_needs_aligned, sample_valid, aligned)
	`IPD_ASSERT_NOW(a_ready_when_empty, !out_valid_q, stream_ready)
	`IPD_ASSERT_NEXT(a_s1_held_on_stall, s1_valid_q && !advance,
		s1_valid_q && word_s1 == $past(word_s1) && word_index_q == $past(word_index_q))

endmodule

>>> rtl/ipd_timekeeper.sv
// Timekeeper: extends the 32-bit packet timestamp with a wrap counter, holds
// the ping registers, time offset and alignment. Depends on ipd_pkg.
module ipd_timekeeper (
	input  logic             clk,
	input  logic             arst_n,
	input  ipd_pkg::tk_ctl_t ctl,
	input  ipd_pkg::cfg_wr_t cfg,
	output logic             aligned,
	output logic [63:0]      time_base
);
	import ipd_pkg::*;

	logic [63:0] ping_time_q;
	logic [31:0] ping_offset_q;
	logic [63:0] ping_delta_q;   // ping_offset - ping_time
	logic [31:0] wrap_q;
	logic [31:0] prev_low_q;
	logic [63:0] packet_time_q;
	logic [63:0] time_offset_q;
	logic [63:0] base_q;         // packet_time - time_offset
	logic        aligned_q;
	logic        started_q;

	logic [31:0] wrap_next;
	logic [63:0] packet_time_next;

	always_comb begin
		wrap_next = wrap_q;
		if (prev_low_q > ctl.stamp && started_q) begin
			wrap_next = wrap_q + 32'd1;
		end
		packet_time_next = {wrap_next, ctl.stamp};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ping_time_q   <= '0;
			ping_offset_q <= '0;
			ping_delta_q  <= '0;
		end else if (cfg.wr) begin
			case (cfg.index)
				CFG_PING_TIME: begin
					ping_time_q  <= cfg.data;
					ping_delta_q <= {32'd0, ping_offset_q} - cfg.data;
				end
				CFG_PING_OFFSET: begin
					ping_offset_q <= cfg.data[31:0];
					ping_delta_q  <= {32'd0, cfg.data[31:0]} - ping_time_q;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wrap_q        <= '0;
			prev_low_q    <= '0;
			packet_time_q <= '0;
			time_offset_q <= '0;
			base_q        <= '0;
			aligned_q     <= 1'b0;
			started_q     <= 1'b0;
		end else begin
			if (ctl.stamp_word) begin
				wrap_q        <= wrap_next;
				prev_low_q    <= ctl.stamp;
				packet_time_q <= packet_time_next;
				base_q        <= packet_time_next - time_offset_q;
				if (ctl.data_chan && aligned_q) begin
					started_q <= 1'b1;
				end
			end
			if (ctl.ping_reply) begin
				time_offset_q <= packet_time_q + ping_delta_q;
				aligned_q     <= 1'b1;
			end
		end
	end

	assign aligned   = aligned_q;
	assign time_base = base_q;

`include "inband_packet_deframer_core_macros.svh"

	`IPD_ASSERT_NOW(a_started_needs_aligned, started_q, aligned_q)
	`IPD_ASSERT_NEXT(a_wrap_only_on_stamp, !ctl.stamp_word, wrap_q == $past(wrap_q))
	`IPD_ASSERT_NEXT(a_wrap_steps_by_one, ctl.stamp_word,
		wrap_q == $past(wrap_q) || wrap_q == $past(wrap_q) + 32'd1)

endmodule

>>> tb/sv/tb_top.sv
// Self-checking testbench for inband_packet_deframer_core.
// Depends on ipd_pkg and the deframer RTL; predicts every sample in-line.
`timescale 1ns / 1ps

module tb_top;
	import ipd_pkg::*;

	localparam int IDLE_PCT  = 12;
	localparam int SETTLE    = 6;     // pipeline is two deep, leave some margin
	localparam int STALL_MAX = 2000;
	localparam int RAND_PKTS = 4;

	// indexes with no register behind them, writes must be dropped
	localparam logic [1:0] CFG_SPARE_LO = 2'd2;
	localparam logic [1:0] CFG_SPARE_HI = 2'd3;

	typedef struct packed {
		logic [31:0] word;
		logic [63:0] stamp;
		logic [5:0]  rssi;
		logic        under;
	} sample_t;

	typedef struct packed {
		logic        cfg;      // rewrite ping registers before this packet
		logic [63:0] ping_t;
		logic [31:0] ping_o;
		logic [4:0]  chan;
		logic [5:0]  rssi;
		logic        under;
		logic [8:0]  bytes;
		logic        junk;     // fill unused header bits with ones
		logic [31:0] stamp;
		logic [31:0] w2;
		int          n_out;    // samples this packet must produce
	} pkt_row_t;

	pkt_row_t plan [16] = '{
		// after reset: data channel, not aligned yet
		'{1'b1, 64'h0000_0000_ffff_ffff, 32'h0, CHAN_DATA, 6'h00, 1'b0, 9'h1ff, 1'b0,
			32'h0000_0010, 32'h0102_0000, 0},
		// other channel dropped; lower stamp does not wrap before timing starts
		'{1'b0, 64'h0, 32'h0, 5'h05, 6'h3f, 1'b1, 9'h1ff, 1'b1,
			32'h0000_0008, 32'h0102_0000, 0},
		// control packet without the ping tag
		'{1'b0, 64'h0, 32'h0, CHAN_CTRL, 6'h00, 1'b0, 9'h000, 1'b0,
			32'h0000_0020, 32'h0101_ffff, 0},
		// ping reply aligns
		'{1'b1, 64'h0, 32'h0, CHAN_CTRL, 6'h00, 1'b0, 9'h000, 1'b0,
			32'h0000_1000, 32'h0102_abcd, 0},
		// first aligned data packet: lower stamp, still no wrap; payload capped
		'{1'b0, 64'h0, 32'h0, CHAN_DATA, 6'h2a, 1'b1, 9'h1ff, 1'b0,
			32'h0000_0200, 32'h1234_5678, 126},
		'{1'b0, 64'h0, 32'h0, CHAN_DATA, 6'h15, 1'b0, 9'h000, 1'b0,
			32'h0000_0280, 32'h0000_0000, 0},
		// byte count truncated to whole words
		'{1'b0, 64'h0, 32'h0, CHAN_DATA, 6'h15, 1'b0, 9'h003, 1'b0,
			32'h0000_0300, 32'h0000_0000, 0},
		'{1'b0, 64'h0, 32'h0, CHAN_DATA, 6'h15, 1'b1, 9'h007, 1'b0,
			32'h0000_0380, 32'hffff_ffff, 1},
		// timestamp wrap
		'{1'b0, 64'h0, 32'h0, CHAN_DATA, 6'h0f, 1'b0, 9'h008, 1'b0,
			32'h0000_0100, 32'h8000_0001, 2},
		'{1'b1, 64'hffff_ffff_ffff_ffff, 32'hffff_ffff, CHAN_CTRL, 6'h00, 1'b0, 9'h000, 1'b0,
			32'hffff_fff0, 32'h0102_0000, 0},
		'{1'b0, 64'h0, 32'h0, CHAN_DATA, 6'h00, 1'b0, 9'h010, 1'b1,
			32'hffff_ffff, 32'h5555_aaaa, 4},
		'{1'b1, 64'h8000_0000_0000_0000, 32'h0, CHAN_CTRL, 6'h00, 1'b0, 9'h000, 1'b0,
			32'h0000_0000, 32'h0102_ffff, 0},
		'{1'b0, 64'h0, 32'h0, CHAN_DATA, 6'h3f, 1'b0, 9'h1fc, 1'b0,
			32'h0000_0010, 32'haaaa_5555, 126},
		// other channel still extends time across a wrap
		'{1'b0, 64'h0, 32'h0, 5'h1e, 6'h3f, 1'b1, 9'h1ff, 1'b1,
			32'h0000_0005, 32'h0102_0000, 0},
		'{1'b1, 64'h0123_4567_89ab_cdef, 32'h8000_0000, CHAN_CTRL, 6'h3f, 1'b1, 9'h1ff, 1'b1,
			32'h0000_0080, 32'h0102_5555, 0},
		'{1'b0, 64'h0, 32'h0, CHAN_DATA, 6'h01, 1'b1, 9'h0fc, 1'b0,
			32'h0000_0100, 32'h0000_0000, 63}
	};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        stream_valid;
	logic        stream_ready;
	logic [31:0] stream_word;
	logic        sample_valid;
	logic        sample_ready = 1'b0;
	logic [31:0] sample_word;
	logic [63:0] sample_time;
	logic [5:0]  rssi;
	logic        underrun;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [63:0] cfg_data;

	sample_t expected_samples [$];
	int      mismatches   = 0;
	int      samples_seen = 0;
	int      stalled      = 0;
	bit      steady       = 1'b0;   // no idling on either side while set

	// deframer state as seen by the predictor
	int          pos        = 0;
	logic [4:0]  cur_chan   = '0;
	int          cur_words  = 0;
	logic [63:0] cur_time   = '0;
	logic [31:0] wraps      = '0;
	logic [31:0] last_low   = '0;
	logic [63:0] offs       = '0;
	bit          locked     = 1'b0;
	bit          timing_on  = 1'b0;
	logic [5:0]  cur_rssi   = '0;
	logic        cur_under  = 1'b0;
	logic [63:0] ping_t_reg = '0;
	logic [31:0] ping_o_reg = '0;

	inband_packet_deframer_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.stream_valid (stream_valid),
		.stream_ready (stream_ready),
		.stream_word  (stream_word),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample_word  (sample_word),
		.sample_time  (sample_time),
		.rssi         (rssi),
		.underrun     (underrun),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// advance the deframer state by one stream word, queue the sample it yields
	task automatic deframe(input logic [31:0] w);
		sample_t s;
		int      k;
		k = pos - 2;
		if (pos == IDX_HEADER) begin
			cur_chan  = w[20:16];
			cur_words = (int'(w[8:2]) > PACKET_WORDS - 2) ? PACKET_WORDS - 2 : int'(w[8:2]);
			cur_under = w[30];
			cur_rssi  = w[26:21];
		end else if (pos == IDX_STAMP) begin
			if (last_low > w && timing_on)
				wraps = wraps + 32'd1;
			cur_time = {wraps, w};
			last_low = w;
			if (cur_chan == CHAN_DATA && locked)
				timing_on = 1'b1;
		end else if (cur_chan == CHAN_CTRL) begin
			if (pos == IDX_PING && w[31:16] == PING_REPLY_TAG) begin
				offs   = cur_time - ping_t_reg + {32'd0, ping_o_reg};
				locked = 1'b1;
			end
		end else if (cur_chan == CHAN_DATA && locked && k < cur_words) begin
			s.word  = w;
			s.stamp = cur_time + 64'(k) - offs;
			s.rssi  = cur_rssi;
			s.under = cur_under;
			expected_samples.push_back(s);
		end
		pos = (pos + 1) % PACKET_WORDS;
	endtask

	task automatic send_word(input logic [31:0] w);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			stream_valid <= 1'b0;
			@(posedge clk);
		end
		stream_valid <= 1'b1;
		stream_word  <= w;
		do @(posedge clk); while (!stream_ready);
		deframe(w);
	endtask

	task automatic send_packet(input logic [31:0] hdr, input logic [31:0] stamp,
			input logic [31:0] w2);
		send_word(hdr);
		send_word(stamp);
		send_word(w2);
		for (int k = 3; k < PACKET_WORDS; k++)
			send_word(k == 3 ? 32'h0 : (k == 4 ? 32'hffff_ffff : $urandom));
	endtask

	// hold the stream off until every sample is back and the pipe has emptied
	task automatic drain();
		stream_valid <= 1'b0;
		while (expected_samples.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// only called while idle; valid stays high across the three requests
	task automatic write_ping(input logic [63:0] pt, input logic [31:0] po);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_PING_TIME;
		cfg_data  <= pt;
		do @(posedge clk); while (!cfg_ready);
		ping_t_reg = pt;
		cfg_index <= CFG_PING_OFFSET;
		cfg_data  <= {$urandom, po};    // upper half is not part of the register
		do @(posedge clk); while (!cfg_ready);
		ping_o_reg = po;
		cfg_index <= $urandom_range(1) ? CFG_SPARE_HI : CFG_SPARE_LO;
		cfg_data  <= {$urandom, $urandom};
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	function automatic void check_field(input string what, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
			mismatches++;
		end
	endfunction

	// sample side: check, random back-pressure, and the stall watchdog
	always @(posedge clk) begin
		sample_t s;
		if (arst_n && sample_valid && sample_ready) begin
			samples_seen++;
			if (expected_samples.size() == 0) begin
				$display("%0t: unexpected sample: expected none, got word %h time %h",
					$time, sample_word, sample_time);
				mismatches++;
			end else begin
				s = expected_samples.pop_front();
				check_field("sample_word", 64'(s.word), 64'(sample_word));
				check_field("sample_time", s.stamp, sample_time);
				check_field("rssi", 64'(s.rssi), 64'(rssi));
				check_field("underrun", 64'(s.under), 64'(underrun));
			end
		end
		sample_ready <= steady || $urandom_range(99) >= IDLE_PCT;

		if (!arst_n || (stream_valid && stream_ready) || (sample_valid && sample_ready)
				|| (cfg_valid && cfg_ready))
			stalled = 0;
		else
			stalled++;
		if (stalled >= STALL_MAX) begin
			$display("%0t: no request accepted for %0d cycles", $time, STALL_MAX);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		pkt_row_t    r;
		int          base;
		int          kind;
		logic [31:0] hdr;
		logic [31:0] w2;
		logic [31:0] stamp;
		logic [63:0] pt;
		logic [31:0] po;

		arst_n       = 1'b0;
		stream_valid = 1'b0;
		stream_word  = '0;
		cfg_valid    = 1'b0;
		cfg_index    = CFG_PING_TIME;
		cfg_data     = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed packets, drained one at a time so per-packet counts can be checked
		for (int i = 0; i < $size(plan); i++) begin
			r = plan[i];
			if (r.cfg)
				write_ping(r.ping_t, r.ping_o);
			steady = (i == 11 || i == 12);
			base   = samples_seen;
			send_packet({r.junk, r.under, {3{r.junk}}, r.rssi, r.chan, {7{r.junk}}, r.bytes},
				r.stamp, r.w2);
			drain();
			if (samples_seen - base != r.n_out) begin
				$display("%0t: packet %0d sample count: expected %0d, got %0d",
					$time, i, r.n_out, samples_seen - base);
				mismatches++;
			end
		end
		steady = 1'b0;

		// random packets: mostly data and ping replies, stamps mostly advancing
		stamp = 32'h0000_0100;
		for (int p = 0; p < RAND_PKTS; p++) begin
			kind = $urandom_range(9);
			hdr  = $urandom;
			w2   = $urandom;
			if (kind < 5)
				hdr[20:16] = CHAN_DATA;
			else if (kind < 8)
				hdr[20:16] = CHAN_CTRL;
			else
				hdr[20:16] = 5'($urandom_range(30, 1));
			if (kind == 5 || kind == 6)
				w2[31:16] = PING_REPLY_TAG;
			stamp = ($urandom_range(4) == 0) ? $urandom : stamp + PACKET_WORDS;
			send_packet(hdr, stamp, w2);
			if ($urandom_range(2) == 0) begin
				drain();
				case ($urandom_range(2))
					0:       pt = '0;
					1:       pt = '1;
					default: pt = {$urandom, $urandom};
				endcase
				case ($urandom_range(2))
					0:       po = '0;
					1:       po = '1;
					default: po = $urandom;
				endcase
				write_ping(pt, po);
			end
		end

		drain();
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
